// ===== rtl/core/dsw_pkg.sv =====
// Shared types and constants for the depth span writer.
`timescale 1ns / 1ps

package dsw_pkg;

    // Longest span that one request may describe, and screen size limit.
    localparam int MAX_SPAN = 64;
    localparam int MAX_DIM  = 1024;

    localparam int COORD_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int ACC_W    = 32;
    localparam int OFFS_W   = 20;
    localparam int DEPTH_W  = 16;
    localparam int RWID_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd3;

    localparam logic [RWID_W-1:0] ROW_WIDTH_RESET = 11'd320;

    typedef struct packed {
        logic [ACC_W-1:0]  origin;
        logic [ACC_W-1:0]  step_x;
        logic [ACC_W-1:0]  step_y;
        logic [RWID_W-1:0] row_width;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the accepted span request
        logic mult;     // form the three products
        logic load;     // set accumulator, offset and pixel count
        logic emit;     // push one pixel write to the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_empty;  // request on the input carries a zero pixel count
        logic out_free;  // output register can take a write this cycle
        logic left_one;  // the next write is the final one of the span
    } t_sts;

endpackage

// ===== rtl/core/dsw_regs.sv =====
// Configuration register file for the depth span writer.
`timescale 1ns / 1ps

module dsw_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [dsw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsw_pkg::ACC_W-1:0]     i_cfg_data,
    output logic                          o_cfg_ready,
    output dsw_pkg::t_cfg                 o_cfg
);
    import dsw_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin    <= '0;
            r_cfg.step_x    <= '0;
            r_cfg.step_y    <= '0;
            r_cfg.row_width <= ROW_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN:    r_cfg.origin    <= i_cfg_data;
                CFG_STEP_X:    r_cfg.step_x    <= i_cfg_data;
                CFG_STEP_Y:    r_cfg.step_y    <= i_cfg_data;
                CFG_ROW_WIDTH: r_cfg.row_width <= i_cfg_data[RWID_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/dsw_ctrl.sv =====
// Sequencing state machine for the depth span writer.
`timescale 1ns / 1ps

module dsw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dsw_pkg::t_sts i_sts,
    output dsw_pkg::t_cmd o_cmd
);
    import dsw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MULT = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mult    = (r_state == ST_MULT);
        o_cmd.load    = (r_state == ST_LOAD);
        o_cmd.emit    = (r_state == ST_RUN) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // an empty span is taken and dropped
                if (i_in_valid && !i_sts.in_empty) n_state = ST_MULT;
            end
            ST_MULT: n_state = ST_LOAD;
            ST_LOAD: n_state = ST_RUN;
            ST_RUN: begin
                if (i_sts.out_free && i_sts.left_one) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/dsw_dp.sv =====
// Datapath: span setup products, depth accumulator, offset counter, output register.
`timescale 1ns / 1ps

module dsw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsw_pkg::t_cfg                 i_cfg,
    input  dsw_pkg::t_cmd                 i_cmd,
    output dsw_pkg::t_sts                 o_sts,
    input  logic [dsw_pkg::COORD_W-1:0]   i_start_column,
    input  logic [dsw_pkg::COORD_W-1:0]   i_row,
    input  logic [dsw_pkg::COUNT_W-1:0]   i_pixel_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dsw_pkg::OFFS_W-1:0]    o_buffer_offset,
    output logic signed [dsw_pkg::DEPTH_W-1:0] o_depth_value,
    output logic                          o_last_of_span
);
    import dsw_pkg::*;

    logic [COORD_W-1:0] n_col;
    logic [COORD_W-1:0] n_row;
    logic [COUNT_W-1:0] n_count;

    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [COUNT_W-1:0] r_count;

    logic [ACC_W-1:0]   r_prod_x;
    logic [ACC_W-1:0]   r_prod_y;
    logic [OFFS_W-1:0]  r_row_offs;

    logic [ACC_W-1:0]   r_acc;
    logic [OFFS_W-1:0]  r_offset;
    logic [COUNT_W-1:0] r_left;

    logic               r_out_valid;
    logic [OFFS_W-1:0]  r_out_offset;
    logic [DEPTH_W-1:0] r_out_depth;
    logic               r_out_last;

    // clamp coordinates and pixel count
    always_comb begin
        n_col   = (32'(i_start_column) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : i_start_column;
        n_row   = (32'(i_row) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : i_row;
        n_count = (32'(i_pixel_count) > MAX_SPAN) ? COUNT_W'(MAX_SPAN) : i_pixel_count;
    end

    assign o_sts.in_empty = (i_pixel_count == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.left_one = (r_left == COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_count <= n_count;
        end
        if (i_cmd.mult) begin
            r_prod_x   <= ACC_W'({{(ACC_W-COORD_W){1'b0}}, r_col} * i_cfg.step_x);
            r_prod_y   <= ACC_W'({{(ACC_W-COORD_W){1'b0}}, r_row} * i_cfg.step_y);
            r_row_offs <= OFFS_W'({{(OFFS_W-COORD_W){1'b0}}, r_row}
                                  * {{(OFFS_W-RWID_W){1'b0}}, i_cfg.row_width});
        end
        if (i_cmd.emit) begin
            r_out_offset <= r_offset;
            r_out_depth  <= r_acc[ACC_W-1 -: DEPTH_W];
            r_out_last   <= (r_left == COUNT_W'(1));
        end
    end

    // span state, wraps freely
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_offset <= '0;
            r_left   <= '0;
        end else if (i_cmd.load) begin
            r_acc    <= i_cfg.origin + r_prod_x + r_prod_y;
            r_offset <= r_row_offs + OFFS_W'(r_col);
            r_left   <= r_count;
        end else if (i_cmd.emit) begin
            r_acc    <= r_acc + i_cfg.step_x;
            r_offset <= r_offset + OFFS_W'(1);
            r_left   <= r_left - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_buffer_offset = r_out_offset;
    assign o_depth_value   = r_out_depth;
    assign o_last_of_span  = r_out_last;

endmodule

// ===== rtl/core/depth_span_writer.sv =====
// Top level of the depth span writer: config registers, controller and datapath.
`timescale 1ns / 1ps

// Usage:
// - Span request channel (i_in_valid / o_in_stall): start column, row and pixel
//   count. A request is taken when valid is high and stall is low.
// - Write channel (o_out_valid / i_out_stall): one depth-buffer write per pixel,
//   in column order, with buffer offset row*row_width+column and the upper 16
//   bits of the inverse-depth accumulator; o_last_of_span marks the final one.
// - Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while
//   no span is in flight.
// Sequence: a span of N pixels (N clamped to 64) holds the request channel
//   until its last write: it is taken, the three setup multiplies run, the
//   accumulator is loaded, then one pixel per cycle from the accumulator add
//   while the receiver does not stall; the first write follows the load step.
// A zero-length request is taken and produces nothing.
// Receiver stall freezes the output register and the pixel walk; the next
//   request can be taken while the last write still waits in the output reg.
// Reset clears the state machine and accumulator; row_width resets to 320,
//   the gradients to zero.

module depth_span_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // span requests
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dsw_pkg::COORD_W-1:0]        i_start_column,
    input  logic [dsw_pkg::COORD_W-1:0]        i_row,
    input  logic [dsw_pkg::COUNT_W-1:0]        i_pixel_count,
    // pixel writes
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [dsw_pkg::OFFS_W-1:0]         o_buffer_offset,
    output logic signed [dsw_pkg::DEPTH_W-1:0] o_depth_value,
    output logic                               o_last_of_span,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dsw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dsw_pkg::ACC_W-1:0]          i_cfg_data
);
    import dsw_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // Register file: origin, x/y gradients, row width.
    dsw_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Sequencer: idle -> multiply -> load -> run (one pixel per free cycle).
    dsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Setup products, accumulator walk and the output register.
    dsw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_start_column  (i_start_column),
        .i_row           (i_row),
        .i_pixel_count   (i_pixel_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_buffer_offset (o_buffer_offset),
        .o_depth_value   (o_depth_value),
        .o_last_of_span  (o_last_of_span)
    );

endmodule

// ===== verif/dsw_span_checker.sv =====
// Checker for the depth span writer: predicts pixel writes and compares them.
`timescale 1ns / 1ps

module dsw_span_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [dsw_pkg::COORD_W-1:0]        i_start_column,
    input  logic [dsw_pkg::COORD_W-1:0]        i_row,
    input  logic [dsw_pkg::COUNT_W-1:0]        i_pixel_count,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [dsw_pkg::OFFS_W-1:0]         i_buffer_offset,
    input  logic signed [dsw_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic                               i_last_of_span,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [dsw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dsw_pkg::ACC_W-1:0]          i_cfg_data,
    output int                                 o_pending,
    output int                                 o_mismatches
);
    import dsw_pkg::*;

    typedef struct packed {
        logic [OFFS_W-1:0]  offset;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } t_pixel_write;

    t_pixel_write expected_writes[$];
    t_pixel_write want;
    t_pixel_write got;
    t_cfg         shadow_cfg;

    // Expand one accepted span into its pixel writes.
    task automatic predict_span_writes(input logic [COORD_W-1:0] col_in,
                                       input logic [COORD_W-1:0] row_in,
                                       input logic [COUNT_W-1:0] count_in);
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        int unsigned        count;
        logic [ACC_W-1:0]   acc;
        logic [31:0]        offs;
        t_pixel_write       w;
        col   = (col_in >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : col_in;
        row   = (row_in >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : row_in;
        count = count_in;
        if (count > MAX_SPAN)
            count = MAX_SPAN;
        acc  = shadow_cfg.origin + ACC_W'(row) * shadow_cfg.step_y
             + ACC_W'(col) * shadow_cfg.step_x;
        offs = 32'(row) * 32'(shadow_cfg.row_width) + 32'(col);
        for (int unsigned k = 0; k < count; k++) begin
            w.offset = offs[OFFS_W-1:0];
            w.depth  = acc[ACC_W-1:ACC_W-DEPTH_W];
            w.last   = (k == count - 1);
            expected_writes.push_back(w);
            acc  = acc + shadow_cfg.step_x;
            offs = offs + 32'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_cfg.origin    = '0;
            shadow_cfg.step_x    = '0;
            shadow_cfg.step_y    = '0;
            shadow_cfg.row_width = ROW_WIDTH_RESET;
            expected_writes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_buffer_offset, i_depth_value, i_last_of_span};
                if (expected_writes.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= 10)
                        $display("%0t: unexpected write offset=%0d depth=%h last=%0b",
                                 $realtime, got.offset, got.depth, got.last);
                end else begin
                    want = expected_writes.pop_front();
                    if (got != want) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= 10)
                            $display("%0t: write mismatch offset exp %0d got %0d,",
                                     $realtime, want.offset, got.offset,
                                     " depth exp %h got %h,", want.depth, got.depth,
                                     " last exp %0b got %0b", want.last, got.last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN:    shadow_cfg.origin    = i_cfg_data;
                    CFG_STEP_X:    shadow_cfg.step_x    = i_cfg_data;
                    CFG_STEP_Y:    shadow_cfg.step_y    = i_cfg_data;
                    CFG_ROW_WIDTH: shadow_cfg.row_width = i_cfg_data[RWID_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_span_writes(i_start_column, i_row, i_pixel_count);
        end
        o_pending = expected_writes.size();
    end

endmodule

// ===== verif/tb_depth_span_writer.sv =====
// Testbench top for the depth span writer: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_depth_span_writer;
    import dsw_pkg::*;

    // Cycles to let the setup pipeline empty out after the last expected write;
    // a zero-length span gives nothing to wait for, so this covers it too.
    localparam int SETTLE_CYCLES  = 10;
    // Cycles without any accepted request, write or config before giving up.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_SPANS   = 44;   // per random phase, three phases

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [COORD_W-1:0]        start_column = '0;
    logic [COORD_W-1:0]        row = '0;
    logic [COUNT_W-1:0]        pixel_count = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [OFFS_W-1:0]         buffer_offset;
    logic signed [DEPTH_W-1:0] depth_value;
    logic                      last_of_span;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_ORIGIN;
    logic [ACC_W-1:0]          cfg_data = '0;

    int writes_pending;
    int mismatches;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    depth_span_writer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_column (start_column),
        .i_row          (row),
        .i_pixel_count  (pixel_count),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_buffer_offset(buffer_offset),
        .o_depth_value  (depth_value),
        .o_last_of_span (last_of_span),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    dsw_span_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_start_column (start_column),
        .i_row          (row),
        .i_pixel_count  (pixel_count),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_buffer_offset(buffer_offset),
        .i_depth_value  (depth_value),
        .i_last_of_span (last_of_span),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (writes_pending),
        .o_mismatches   (mismatches)
    );

    // Receiver back-pressure: a fresh coin per cycle at the current rate.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Watchdog: restarts on any handshake, so long spans under heavy stall
    // never trip it, only a block that stops moving does.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_depth_span_writer NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one span request and hold it until taken. Valid stays high
    // straight into the next request when the sender does not idle.
    task automatic send_span(input int col, input int rw, input int count);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        start_column <= COORD_W'(col);
        row          <= COORD_W'(rw);
        pixel_count  <= COUNT_W'(count);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted write, then let the pipe go quiet
    // so config writes land while the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (writes_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; valid stays up across them.
    task automatic program_gradients(input logic [ACC_W-1:0] origin,
                                     input logic [ACC_W-1:0] step_x,
                                     input logic [ACC_W-1:0] step_y,
                                     input logic [ACC_W-1:0] row_width_word);
        logic [CFG_IDX_W-1:0] reg_index [4];
        logic [ACC_W-1:0]     reg_value [4];
        reg_index = '{CFG_ORIGIN, CFG_STEP_X, CFG_STEP_Y, CFG_ROW_WIDTH};
        reg_value = '{origin, step_x, step_y, row_width_word};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data  <= reg_value[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly short spans, some up to the limit, a few empty or overlong.
    task automatic send_random_span();
        int pick;
        int count;
        pick = $urandom_range(99);
        if (pick < 75)
            count = $urandom_range(16, 1);
        else if (pick < 88)
            count = $urandom_range(64, 17);
        else if (pick < 94)
            count = 0;
        else
            count = $urandom_range(127, 65);
        send_span($urandom_range(1023), $urandom_range(1023), count);
    endtask

    task automatic program_random_gradients();
        logic [ACC_W-1:0] row_width_word;
        case ($urandom_range(3))
            0: row_width_word = 1;
            1: row_width_word = 1024;
            2: row_width_word = $urandom_range(1024, 1);
            default: row_width_word = $urandom;  // may wrap to 0 or exceed 1024
        endcase
        program_gradients($urandom, $urandom, $urandom, row_width_word);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 28;
        receiver_idle_pct = 79;

        // Directed spans on reset config: row_width 320, flat zero depth.
        send_span(0, 0, 1);
        send_span(1023, 1023, 64);
        send_span(1023, 0, 1);
        send_span(0, 1023, 1);
        send_span(5, 7, 0);              // empty span, nothing comes out
        send_span(100, 3, 65);           // overlong, cut to the max span
        send_span(2, 2, 127);
        settle();

        // Accumulator overflow on every step, row_width above 1024.
        program_gradients(32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_07FF);
        send_span(512, 511, 2);
        send_span(341, 682, 85);
        send_span(682, 341, 42);
        send_span(1023, 1023, 64);
        send_span(0, 0, 0);
        settle();

        // Most negative origin and x gradient, y gradient -1; row_width written as 0 with high bits set.
        program_gradients(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_F800);
        send_span(1023, 1023, 3);
        send_span(7, 1023, 64);
        send_span(1000, 0, 33);
        settle();

        // Realistic small gradients and row_width 1, then 1024.
        program_gradients(32'h4000_0000, 32'hFFFF_8000, 32'h0001_0000, 32'd1);
        send_span(1023, 1023, 16);
        send_span(0, 500, 64);
        settle();
        program_gradients(32'h0000_0000, 32'h0000_8000, 32'hFFF0_0000, 32'd1024);
        send_span(1023, 1023, 64);
        send_span(300, 200, 10);
        settle();

        // Random phases: heavy receiver stall, then heavy sender gaps, then none.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 79 : 0;
            receiver_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 28 : 0;
            program_random_gradients();
            repeat (RANDOM_SPANS) send_random_span();
            settle();
        end

        if (mismatches == 0)
            $display("tb_depth_span_writer OK");
        else
            $display("tb_depth_span_writer NOT OK");
        $finish;
    end

endmodule

// ===== depth_span_writer.f =====
rtl/core/dsw_pkg.sv
rtl/core/dsw_regs.sv
rtl/core/dsw_ctrl.sv
rtl/core/dsw_dp.sv
rtl/core/depth_span_writer.sv
verif/dsw_span_checker.sv
verif/tb_depth_span_writer.sv
